@@ rtl/mbfc_pkg.sv @@
// ----------------------------------------------------------------------------
// mbfc_pkg: shared types, coefficient tables and fixed-point helpers
// Beat types, the decimal coefficient sets and rounding/saturation functions.
// ----------------------------------------------------------------------------
`default_nettype none
package mbfc_pkg;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [23:0] sample_in;
  } in_t;

  typedef struct packed {
    logic [2:0]         channel_out;
    logic signed [23:0] sample_out;
  } out_t;

  typedef struct packed {
    logic               skip;
    logic [2:0]         ch;
    logic signed [31:0] x;
  } stage_t;

  localparam int RomBp    = 7;
  localparam int RomNotch = 6;
  localparam logic [63:0] DecOne  = 64'd10000000000;
  localparam logic [63:0] DecHalf = DecOne / 64'd2;
  localparam logic [0:0] REG_RATE = 1'b0;

  localparam logic signed [63:0] COEF_DEC [2][3][7][5] = '{
    '{
      '{
        '{64'sd4797780216, 64'sd9593143416, 64'sd4797780216, -64'sd19958369730, -64'sd9972631931},
        '{64'sd4797780216, -64'sd9594486329, 64'sd4797780216, 64'sd19975401160, -64'sd9981743693},
        '{64'sd9943896532, 64'sd19884325757, 64'sd9943896532, 64'sd19910217520, -64'sd9919091463},
        '{64'sd9943896532, -64'sd19886252039, 64'sd9943896532, -64'sd19858983760, -64'sd9878907204},
        '{64'sd9771189690, 64'sd19541225051, 64'sd9771189690, 64'sd19633369450, -64'sd9655727148},
        '{64'sd9771189690, -64'sd19541865699, 64'sd9771189690, -64'sd19438471790, -64'sd9488319755},
        '{64'sd38126153950, 64'sd0, -64'sd38126153950, 64'sd479340740, 64'sd7603674531}
      },
      '{
        '{64'sd15608187910, -64'sd10270875033, 64'sd15608187910, 64'sd7267251015, -64'sd9744894505},
        '{64'sd15608187910, -64'sd9037974307, 64'sd15608187910, 64'sd4900162220, -64'sd9734368920},
        '{64'sd48704876900, -64'sd30870635879, 64'sd48704876900, 64'sd3904991150, -64'sd8411195278},
        '{64'sd48704876900, -64'sd29404259696, 64'sd48704876900, 64'sd7413055301, -64'sd8502965569},
        '{64'sd1119695157, -64'sd750477346, 64'sd1119695157, 64'sd7111777663, -64'sd9948909283},
        '{64'sd1119695157, -64'sd634260532, 64'sd1119695157, 64'sd5201193094, -64'sd9947212338},
        '{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0}
      },
      '{
        '{64'sd16089665890, -64'sd25854098224, 64'sd16089665890, 64'sd15683093070, -64'sd9836370945},
        '{64'sd16089665890, -64'sd26224601718, 64'sd16089665890, 64'sd16404006480, -64'sd9849433303},
        '{64'sd46970534320, -64'sd75817770172, 64'sd46970534320, 64'sd15013834240, -64'sd9147599936},
        '{64'sd46970534320, -64'sd76227993439, 64'sd46970534320, 64'sd15998539920, -64'sd9234134555},
        '{64'sd1220215932, -64'sd1956099434, 64'sd1220215932, 64'sd15857373480, -64'sd9966791868},
        '{64'sd1220215932, -64'sd1993188953, 64'sd1220215932, 64'sd16441680190, -64'sd9968982935},
        '{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0}
      }
    },
    '{
      '{
        '{64'sd4902730882, 64'sd9796635383, 64'sd4902730882, -64'sd19919048550, -64'sd9958600998},
        '{64'sd4902730882, -64'sd9804667497, 64'sd4902730882, 64'sd19983989000, -64'sd9987554550},
        '{64'sd9930749536, 64'sd19848796491, 64'sd9930749536, 64'sd19938833710, -64'sd9943691492},
        '{64'sd9930749536, -64'sd19860356668, 64'sd9930749536, -64'sd19760112760, -64'sd9813702106},
        '{64'sd9714930058, 64'sd19425491730, 64'sd9714930058, 64'sd19742199180, -64'sd9754008055},
        '{64'sd9714930058, -64'sd19429467516, 64'sd9714930058, -64'sd19077731370, -64'sd9204980731},
        '{64'sd35448429580, 64'sd0, -64'sd35448429580, 64'sd1560278684, 64'sd7102911472}
      },
      '{
        '{64'sd15731073620, -64'sd25266880705, 64'sd15731073620, 64'sd15690711740, -64'sd9863000512},
        '{64'sd15731073620, -64'sd25650538797, 64'sd15731073620, 64'sd16435904500, -64'sd9874315262},
        '{64'sd50831875800, -64'sd82036186098, 64'sd50831875800, 64'sd14891707900, -64'sd9139574170},
        '{64'sd50831875800, -64'sd82508607081, 64'sd50831875800, 64'sd16098710300, -64'sd9245311618},
        '{64'sd1121902913, -64'sd1797533077, 64'sd1121902913, 64'sd15857819320, -64'sd9973062277},
        '{64'sd1121902913, -64'sd1833492354, 64'sd1121902913, 64'sd16450474260, -64'sd9974864721},
        '{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0}
      },
      '{
        '{64'sd16158108710, -64'sd30687346548, 64'sd16158108710, 64'sd18845956330, -64'sd9917417169},
        '{64'sd16158108710, -64'sd30785129928, 64'sd16158108710, 64'sd19040467740, -64'sd9924780130},
        '{64'sd47968544960, -64'sd91193437289, 64'sd47968544960, 64'sd18475230930, -64'sd9561412334},
        '{64'sd47968544960, -64'sd91303531672, 64'sd47968544960, 64'sd18768714670, -64'sd9611843824},
        '{64'sd1221401542, -64'sd2318451637, 64'sd1221401542, 64'sd18927204610, -64'sd9983312488},
        '{64'sd1221401542, -64'sd2328208600, 64'sd1221401542, 64'sd19081633090, -64'sd9984539151},
        '{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0}
      }
    }
  };

  function automatic logic signed [31:0] to_q27(input logic signed [63:0] d);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    q   = (mag * 64'd134217728 + DecHalf) / DecOne;
    return (d < 0) ? -$signed(q[31:0]) : $signed(q[31:0]);
  endfunction

  function automatic logic signed [63:0] rnd19(input logic signed [63:0] v);
    return (v + 64'sd262144) >>> 19;
  endfunction

  function automatic logic signed [63:0] rnd8(input logic signed [63:0] v);
    return (v + 64'sd128) >>> 8;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sd140737488355327) return 48'sh7fffffffffff;
    if (v < -64'sd140737488355328) return 48'sh800000000000;
    return v[47:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/mbfc_section_cell.sv @@
// ----------------------------------------------------------------------------
// mbfc_section_cell: one biquad section of the chain
// Holds both delay values for every channel; for an active, unskipped beat
// runs five products on one multiplier and hands the output to the next cell
// ----------------------------------------------------------------------------
`default_nettype none
module mbfc_section_cell import mbfc_pkg::*; #(
  parameter int CHANNELS = 8,
  parameter int FILT     = 0,
  parameter int KSEC     = 0,
  parameter bit ACTIVE   = 1'b1
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   rate_i,
  input  wire logic   in_valid_i,
  input  wire stage_t in_beat_i,
  output logic        out_valid_o,
  output stage_t      out_beat_o
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KR   = (KSEC < 7) ? KSEC : 6;

  logic signed [31:0] coef0 [5];
  logic signed [31:0] coef1 [5];
  for (genvar i = 0; i < 5; i++) begin : g_coef
    assign coef0[i] = to_q27(COEF_DEC[0][FILT][KR][i]);
    assign coef1[i] = to_q27(COEF_DEC[1][FILT][KR][i]);
  end

  logic signed [47:0] d1_q [CHANNELS];
  logic signed [47:0] d2_q [CHANNELS];
  logic               run_q;
  logic [2:0]         cnt_q;
  stage_t             beat_q;
  logic signed [31:0] y_q;
  logic signed [63:0] a1_q, a2_q, p_q;
  logic               out_valid_q;
  stage_t             out_beat_q;
  logic [IdxW-1:0]    idx;
  logic signed [31:0] coef_sel, opnd;

  assign idx = IdxW'(beat_q.ch);

  always_comb begin
    coef_sel = 32'sd0;
    if (cnt_q < 3'd5) begin
      coef_sel = rate_i ? coef1[cnt_q] : coef0[cnt_q];
    end
    opnd = (cnt_q < 3'd3) ? beat_q.x : y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        d1_q[c] <= '0;
        d2_q[c] <= '0;
      end
    end else begin
      out_valid_q <= in_valid_i ? (in_beat_i.skip || !ACTIVE) : (run_q && cnt_q == 3'd5);
      if (in_valid_i) begin
        beat_q <= in_beat_i;
        cnt_q  <= '0;
        if (in_beat_i.skip || !ACTIVE) begin
          out_beat_q  <= in_beat_i;
        end else begin
          run_q <= 1'b1;
        end
      end else if (run_q) begin
        cnt_q <= cnt_q + 3'd1;
        p_q   <= coef_sel * opnd;
        case (cnt_q)
          3'd1: y_q  <= sat32(rnd8(rnd19(p_q) + 64'(d1_q[idx])));
          3'd2: a1_q <= rnd19(p_q) + 64'(d2_q[idx]);
          3'd3: a2_q <= rnd19(p_q);
          3'd4: d1_q[idx] <= sat48(a1_q + rnd19(p_q));
          3'd5: begin
            d2_q[idx]        <= sat48(a2_q + rnd19(p_q));
            run_q            <= 1'b0;
            out_beat_q.skip  <= beat_q.skip;
            out_beat_q.ch    <= beat_q.ch;
            out_beat_q.x     <= y_q;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule
`default_nettype wire

@@ rtl/multichannel_biquad_filter_chain_core.sv @@
// ----------------------------------------------------------------------------
// multichannel_biquad_filter_chain_core: cascaded biquad filter, 8 channels
// Band-pass, 100 Hz notch and 50 Hz notch sections as a row of cells.
// ----------------------------------------------------------------------------
// Active sections run five products, pass-through sections only register the
// beat; a beat for a channel past CHANNELS passes through every section. A new
// beat is taken once the last has left the chain and the skid slot is empty,
// and a result may wait at the output while the next beat runs.
// Reset clears all delay values and sets the 500 Hz coefficient set.
`default_nettype none
module multichannel_biquad_filter_chain_core import mbfc_pkg::*; #(
  parameter int CHANNELS          = 8,
  parameter int BANDPASS_SECTIONS = 7,
  parameter int NOTCH_SECTIONS    = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_t             out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int Sect = BANDPASS_SECTIONS + 2 * NOTCH_SECTIONS;

  logic   rate_q;
  logic   busy_q;
  logic   out_valid_q, skid_q;
  out_t   out_q, skid_data_q;
  logic   in_fire, out_fire;
  logic   vld [Sect+1];
  stage_t beat [Sect+1];
  out_t   res;

  assign pready = 1'b1;
  assign prdata = (paddr == {REG_RATE, 2'b00}) ? {31'd0, rate_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == {REG_RATE, 2'b00}) begin
      rate_q <= pwdata[0];
    end
  end

  assign in_ready_o = !busy_q && !skid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  assign vld[0]       = in_fire;
  assign beat[0].skip = (32'(in_data_i.channel) >= CHANNELS);
  assign beat[0].ch   = in_data_i.channel;
  assign beat[0].x    = 32'(in_data_i.sample_in) <<< 8;

  for (genvar s = 0; s < Sect; s++) begin : g_cell
    localparam int F = (s < BANDPASS_SECTIONS) ? 0 :
                       (s < BANDPASS_SECTIONS + NOTCH_SECTIONS) ? 1 : 2;
    localparam int K = (F == 0) ? s :
                       (F == 1) ? s - BANDPASS_SECTIONS :
                       s - BANDPASS_SECTIONS - NOTCH_SECTIONS;
    localparam bit A = (F == 0) ? (K < RomBp) : (K < RomNotch);
    mbfc_section_cell #(
      .CHANNELS(CHANNELS), .FILT(F), .KSEC(K), .ACTIVE(A)
    ) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .rate_i(rate_q),
      .in_valid_i(vld[s]), .in_beat_i(beat[s]),
      .out_valid_o(vld[s+1]), .out_beat_o(beat[s+1])
    );
  end

  assign res.channel_out = beat[Sect].ch;
  assign res.sample_out  = beat[Sect].skip ? 24'sd0 : sat24(rnd8(64'(beat[Sect].x)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      skid_q      <= 1'b0;
    end else begin
      if (in_fire) busy_q <= 1'b1;
      else if (vld[Sect]) busy_q <= 1'b0;
      if (out_fire) begin
        if (skid_q) begin
          out_q  <= skid_data_q;
          skid_q <= 1'b0;
        end else if (vld[Sect]) begin
          out_q <= res;
        end else begin
          out_valid_q <= 1'b0;
        end
      end else if (vld[Sect]) begin
        if (out_valid_q) begin
          skid_q      <= 1'b1;
          skid_data_q <= res;
        end else begin
          out_valid_q <= 1'b1;
          out_q       <= res;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_skid_implies_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |-> out_valid_q) else $error("skid full while output empty");
  a_fire_sets_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> busy_q) else $error("accepted beat not tracked");
  a_no_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[Sect] |-> busy_q) else $error("result without beat in flight");
`endif

endmodule
`default_nettype wire

@@ tb/sv/multichannel_biquad_filter_chain_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_biquad_filter_chain_core_test: filter chain self-check
// Drives sample beats with bursty input and a stalling output, predicts each
// result with a bit-exact fixed-point cascade, and cycles the rate register.
// ----------------------------------------------------------------------------
`default_nettype none
module multichannel_biquad_filter_chain_core_test import mbfc_pkg::*; ();

  localparam int NCh   = 8;
  localparam int NSec  = 19;
  localparam int Limit = 20000;
  localparam logic [2:0] RateAddr   = {REG_RATE, 2'b00};
  localparam logic [2:0] UnusedAddr = 3'd4;

  class filter_scoreboard;
    longint    cq[2][3][7][5];
    longint    dl[NCh][NSec][2];
    bit        rate;
    out_t      pending[$];
    int        errors;
    int        checked;

    function new();
      longint unsigned mag, q;
      longint dv;
      for (int r = 0; r < 2; r++)
        for (int f = 0; f < 3; f++)
          for (int k = 0; k < 7; k++)
            for (int i = 0; i < 5; i++) begin
              dv  = COEF_DEC[r][f][k][i];
              mag = (dv < 0) ? -dv : dv;
              q   = (mag * 64'd134217728 + 64'd5000000000) / 64'd10000000000;
              cq[r][f][k][i] = (dv < 0) ? -longint'(q) : longint'(q);
            end
      foreach (dl[c, s, j]) dl[c][s][j] = 0;
      rate = 0;
    endfunction

    function longint half_up(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function longint clip(longint v, int bits);
      longint lim;
      lim = longint'(1) <<< (bits - 1);
      if (v >= lim) return lim - 1;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void note_input(in_t beat);
      longint x, y, acc;
      int     sec;
      out_t   res;
      sec = 0;
      x = longint'(beat.sample_in) * 256;
      for (int f = 0; f < 3; f++)
        for (int k = 0; k < ((f == 0) ? 7 : 6); k++) begin
          acc = half_up(cq[rate][f][k][0] * x, 19) + dl[beat.channel][sec][0];
          y = clip(half_up(acc, 8), 32);
          dl[beat.channel][sec][0] = clip(half_up(cq[rate][f][k][1] * x, 19)
              + half_up(cq[rate][f][k][3] * y, 19) + dl[beat.channel][sec][1], 48);
          dl[beat.channel][sec][1] = clip(half_up(cq[rate][f][k][2] * x, 19)
              + half_up(cq[rate][f][k][4] * y, 19), 48);
          x = y;
          sec++;
        end
      res.channel_out = beat.channel;
      res.sample_out  = 24'(clip(half_up(x, 8), 24));
      pending.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat: channel_out %0d sample_out %0d",
               got.channel_out, got.sample_out);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.channel_out !== want.channel_out) begin
        $error("channel_out mismatch: expected %0d actual %0d",
               want.channel_out, got.channel_out);
        errors++;
      end
      if (got.sample_out !== want.sample_out) begin
        $error("sample_out mismatch: expected %0d actual %0d",
               want.sample_out, got.sample_out);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_t         in_data_i;
  out_t        out_data_o;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  filter_scoreboard sb;
  int burst_left, idle_cycles, hold_req, sent, reg_errors;

  multichannel_biquad_filter_chain_core dut (.*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    in_valid_i = 0; in_data_i = '0; out_ready_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    hold_req = 0;
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);

  initial begin
    int mode, cnt;
    mode = 0; cnt = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        out_ready_i <= 0;
        hold_req = hold_req - 1;
      end else begin
        if (cnt == 0) begin
          mode = $urandom_range(2);
          cnt  = $urandom_range(400, 20);
        end
        cnt--;
        case (mode)
          0: out_ready_i <= 1;
          1: out_ready_i <= ($urandom_range(3) != 0);
          default: out_ready_i <= ($urandom_range(7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= Limit) begin
      $display("watchdog: no beat for %0d cycles", Limit);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_beat(in_t beat);
    @(negedge clk_i);
    in_valid_i <= 1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(beat);
    sent++;
    if (burst_left > 0) burst_left--;
    else begin
      @(negedge clk_i);
      in_valid_i <= 0;
      repeat ($urandom_range(300)) @(negedge clk_i);
      burst_left = $urandom_range(12);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= value;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    if (addr == RateAddr) sb.rate = value[0];
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(negedge clk_i);
    psel <= 1; paddr <= RateAddr;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    if (prdata[0] !== sb.rate) begin
      $error("rate_select readback mismatch: expected %0d actual %0d", sb.rate, prdata[0]);
      reg_errors++;
    end
    @(negedge clk_i);
    psel <= 0; penable <= 0;
  endtask

  function automatic in_t rand_beat();
    in_t b;
    b.channel = 3'($urandom_range(7));
    case ($urandom_range(7))
      0: b.sample_in = 24'sh7fffff;
      1: b.sample_in = 24'sh800000;
      2, 3: b.sample_in = 24'($signed($urandom_range(4000)) - 2000);
      default: b.sample_in = 24'($urandom);
    endcase
    return b;
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) hold_req = 2000;
      if (i == 2 * n / 3) drain();
      send_beat(rand_beat());
    end
  endtask

  initial begin
    in_t b;
    sb = new();
    burst_left = 0; idle_cycles = 0; sent = 0; reg_errors = 0;
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    repeat (5) @(posedge clk_i);

    for (int c = 0; c < NCh; c++) begin
      b.channel = 3'(c);
      b.sample_in = (c % 2) ? 24'sh800000 : 24'sh7fffff;
      send_beat(b);
    end
    for (int i = 0; i < 6; i++) begin
      b.channel = 3'd3;
      b.sample_in = (i % 2) ? 24'sh800000 : 24'sh7fffff;
      send_beat(b);
    end
    b.channel = 3'd0; b.sample_in = 24'sd0; send_beat(b);
    b.channel = 3'd7; b.sample_in = 24'sd1; send_beat(b);
    b.channel = 3'd5; b.sample_in = -24'sd1; send_beat(b);
    random_run(170);

    drain();
    reg_write(RateAddr, 32'd1);
    for (int i = 0; i < 6; i++) begin
      b.channel = 3'd3;
      b.sample_in = (i % 2) ? 24'sh7fffff : 24'sh800000;
      send_beat(b);
    end
    random_run(130);

    drain();
    reg_write(UnusedAddr, 32'd0);
    random_run(30);
    drain();
    reg_write(RateAddr, 32'hffff_fffe);
    random_run(100);

    drain();
    $display("%0d sample beats over 8 channels, both coefficient sets, %0d results checked",
             sent, sb.checked);
    $display("extremes, saturation, rate switch without state clear, ignored register");
    if (sb.errors == 0 && reg_errors == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
